FILE: rtl/emtp_pkg.sv
// Package for the edge matching tile placer: request and result types, status codes, sizes.
// Used by the top level and the checker in rtl/.
package emtp_pkg;

  localparam int unsigned GridSide  = 64;
  localparam int unsigned MaxTiles  = 16;
  localparam int unsigned CoordW    = $clog2(GridSide);
  localparam int unsigned Cells     = GridSide * GridSide;
  localparam int unsigned CellW     = $clog2(Cells);
  localparam int unsigned TileW     = $clog2(MaxTiles);
  localparam int unsigned EdgeW     = 12;
  localparam int unsigned DepthW    = CellW + 1;
  localparam int unsigned StackW    = 2 * CoordW + TileW;

  localparam logic [2:0] StLoaded   = 3'd0;
  localparam logic [2:0] StPlaced   = 3'd1;
  localparam logic [2:0] StRejected = 3'd2;
  localparam logic [2:0] StBacktrack = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StNoTiling = 3'd5;

  typedef struct packed {
    logic             kind;
    logic [3:0]       tile_slot;
    logic [EdgeW-1:0] edge_top;
    logic [EdgeW-1:0] edge_right;
    logic [EdgeW-1:0] edge_bottom;
    logic [EdgeW-1:0] edge_left;
  } req_t;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] column;
    logic [3:0] tried_tile;
    logic [2:0] status;
  } res_t;

endpackage

FILE: rtl/emtp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module emtp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read share the one address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/edge_matching_tile_placer.sv
// Top level of the edge matching tile placer: sequencer, cell, occupancy and stack memories.
// Depends on emtp_pkg and emtp_ram.
//
// Use: a request is taken when start is high and busy is low. kind 0 loads one tile
// into the 16 entry tile table; kind 1 performs one tick of the backtracking search.
// Each request gives exactly one result, shown on result_o for one cycle with done_o.
// The receiver cannot stall; the result is simply presented.
// A load, or a tick on a halted search, answers in the cycle after it is taken.
// A search tick writes its tile in S_PLACE, then reads the four neighbours one at a time
// through the shared cell memory port, each in S_NREQ, S_NWAIT and S_NCHK, decides in
// S_DECIDE, pops stack entries through S_POP, S_POPWAIT and S_POPDO while backtracking
// and gives its result from S_DONE. busy stays high until the result appears, so the next
// request can be taken in the cycle of the result.
// The user must write the tile_count register through cfg_valid_i/cfg_ready_o only while
// idle; the block itself does not enforce it. After reset a clearing pass sweeps every
// cell of the occupancy memory; busy is high and no request is taken meanwhile (configuration
// writes are still taken). Reset also clears the stack depth, position, choice and search flags.
module edge_matching_tile_placer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  emtp_pkg::req_t      req_i,
  output logic                done_o,
  output emtp_pkg::res_t      result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [4:0]          cfg_data_i
);

  localparam int unsigned CW = emtp_pkg::CoordW;
  localparam int unsigned TW = emtp_pkg::TileW;
  localparam int unsigned AW = emtp_pkg::CellW;
  localparam int unsigned DW = emtp_pkg::DepthW;
  localparam int unsigned EW = emtp_pkg::EdgeW;
  localparam logic [CW-1:0] EdgeIdx = CW'(emtp_pkg::GridSide - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PLACE, S_NREQ, S_NWAIT, S_NCHK, S_DECIDE,
    S_POP, S_POPWAIT, S_POPDO, S_DONE
  } state_e;

  state_e state_q;
  logic [4:0]      tile_count_q;
  logic [AW-1:0]   clr_q;
  logic [DW-1:0]   sp_q;
  logic [CW-1:0]   row_q, col_q, hr_q, hc_q;
  logic [4:0]      choice_q;
  logic [TW-1:0]   ch_q;
  logic            started_q, halted_q, fit_q;
  logic [1:0]      nb_q;
  logic [2:0]      status_q;
  logic [EW-1:0]   tt_q [emtp_pkg::MaxTiles][4];
  logic [EW-1:0]   own_q;

  // Memory ports.
  logic            cell_we, stk_we;
  logic [AW-1:0]   cell_addr;
  logic [TW:0]     cell_wdata, cell_rdata;
  logic [AW-1:0]   stk_addr;
  logic [emtp_pkg::StackW-1:0] stk_wdata, stk_rdata;

  // Cell memory holds occupancy in the top bit and the tile below it.
  emtp_ram #(.Width(TW + 1), .Depth(emtp_pkg::Cells)) u_cell (
    .clk_i, .we_i(cell_we), .addr_i(cell_addr), .wdata_i(cell_wdata), .rdata_o(cell_rdata)
  );
  emtp_ram #(.Width(emtp_pkg::StackW), .Depth(emtp_pkg::Cells)) u_stack (
    .clk_i, .we_i(stk_we), .addr_i(stk_addr), .wdata_i(stk_wdata), .rdata_o(stk_rdata)
  );

  // Effective tile count minus one, with the count clamped to one through MaxTiles.
  logic [4:0] eff_m1;
  always_comb begin
    priority if (tile_count_q == 5'd0) eff_m1 = 5'd0;
    else if (tile_count_q > 5'(emtp_pkg::MaxTiles)) eff_m1 = 5'(emtp_pkg::MaxTiles - 1);
    else eff_m1 = tile_count_q - 5'd1;
  end

  // Neighbour under test: right, top, left, bottom; sides as in the tile table.
  logic          nb_exists;
  logic [CW-1:0] nr, nc;
  logic [1:0]    own_side, nb_side;
  always_comb begin
    nr = row_q; nc = col_q; nb_exists = 1'b0; own_side = 2'd1; nb_side = 2'd3;
    unique case (nb_q)
      2'd0: begin nr = row_q + 1'b1; nb_exists = (row_q != EdgeIdx); own_side = 2'd1;
        nb_side = 2'd3; end
      2'd1: begin nc = col_q + 1'b1; nb_exists = (col_q != EdgeIdx); own_side = 2'd0;
        nb_side = 2'd2; end
      2'd2: begin nr = row_q - 1'b1; nb_exists = (row_q != '0); own_side = 2'd3;
        nb_side = 2'd1; end
      default: begin nc = col_q - 1'b1; nb_exists = (col_q != '0); own_side = 2'd2;
        nb_side = 2'd0; end
    endcase
  end

  logic on_edge;
  assign on_edge = (row_q == EdgeIdx) || (col_q == EdgeIdx);

  // Memory control from the sequencer state.
  always_comb begin
    cell_we = 1'b0; cell_addr = {row_q, col_q}; cell_wdata = {1'b1, ch_q};
    stk_we = 1'b0; stk_addr = sp_q[AW-1:0]; stk_wdata = {row_q, col_q, ch_q};
    unique case (state_q)
      S_CLEAR: begin cell_we = 1'b1; cell_addr = clr_q; cell_wdata = '0; end
      S_PLACE: cell_we = 1'b1;
      S_NREQ, S_NWAIT: cell_addr = {nr, nc};
      S_DECIDE: begin
        stk_we = fit_q && (sp_q < DW'(emtp_pkg::Cells));
        cell_we = !fit_q && (ch_q == '0);
        cell_wdata = '0;
      end
      S_POP, S_POPWAIT: stk_addr = AW'(sp_q - 1'b1);
      S_POPDO: begin cell_we = (stk_rdata[TW-1:0] == '0); cell_wdata = '0;
        cell_addr = stk_rdata[emtp_pkg::StackW-1 -: AW]; stk_addr = AW'(sp_q - 1'b1); end
      default: ;
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; tile_count_q <= 5'd16; sp_q <= '0;
      row_q <= '0; col_q <= '0; choice_q <= '0; started_q <= 1'b0; halted_q <= 1'b0;
      done_o <= 1'b0; nb_q <= '0; fit_q <= 1'b0; status_q <= emtp_pkg::StLoaded;
      hr_q <= '0; hc_q <= '0; ch_q <= '0; result_o <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_valid_i) tile_count_q <= cfg_data_i;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(emtp_pkg::Cells - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (start) begin
          if (!req_i.kind) begin
            if (32'(req_i.tile_slot) < emtp_pkg::MaxTiles) begin
              tt_q[TW'(req_i.tile_slot)][0] <= req_i.edge_top;
              tt_q[TW'(req_i.tile_slot)][1] <= req_i.edge_right;
              tt_q[TW'(req_i.tile_slot)][2] <= req_i.edge_bottom;
              tt_q[TW'(req_i.tile_slot)][3] <= req_i.edge_left;
            end
            result_o <= '{row: '0, column: '0, tried_tile: req_i.tile_slot,
                          status: emtp_pkg::StLoaded};
            done_o <= 1'b1;
          end else begin
            logic [4:0] chv;
            chv = started_q ? choice_q : eff_m1;
            started_q <= 1'b1;
            choice_q <= chv;
            if (halted_q || on_edge) begin
              halted_q <= 1'b1;
              result_o <= '{row: 6'(row_q), column: 6'(col_q), tried_tile: '0,
                            status: on_edge ? emtp_pkg::StFull : emtp_pkg::StNoTiling};
              done_o <= 1'b1;
            end else begin
              ch_q <= TW'(chv);
              hr_q <= row_q; hc_q <= col_q;
              nb_q <= '0; fit_q <= 1'b1;
              state_q <= S_PLACE;
            end
          end
        end
        S_PLACE: state_q <= S_NREQ;
        S_NREQ: state_q <= S_NWAIT;
        S_NWAIT: begin
          own_q <= tt_q[ch_q][own_side];
          state_q <= S_NCHK;
        end
        S_NCHK: begin
          if (nb_exists && cell_rdata[TW] &&
              (own_q != tt_q[cell_rdata[TW-1:0]][nb_side])) fit_q <= 1'b0;
          nb_q <= nb_q + 1'b1;
          state_q <= (nb_q == 2'd3) ? S_DECIDE : S_NREQ;
        end
        S_DECIDE: begin
          if (fit_q) begin
            status_q <= emtp_pkg::StPlaced;
            if (sp_q < DW'(emtp_pkg::Cells)) sp_q <= sp_q + 1'b1;
            choice_q <= eff_m1;
            if (col_q < row_q) col_q <= col_q + 1'b1;
            else if (row_q == '0) begin row_q <= col_q + 1'b1; col_q <= '0; end
            else row_q <= row_q - 1'b1;
            state_q <= S_DONE;
          end else if (ch_q != '0) begin
            status_q <= emtp_pkg::StRejected;
            choice_q <= 5'(ch_q) - 5'd1;
            state_q <= S_DONE;
          end else begin
            status_q <= emtp_pkg::StBacktrack;
            state_q <= S_POP;
          end
        end
        S_POP: begin
          if (sp_q == '0) begin
            halted_q <= 1'b1; status_q <= emtp_pkg::StNoTiling; choice_q <= '0;
            state_q <= S_DONE;
          end else state_q <= S_POPWAIT;
        end
        S_POPWAIT: state_q <= S_POPDO;
        S_POPDO: begin
          sp_q <= sp_q - 1'b1;
          row_q <= stk_rdata[emtp_pkg::StackW-1 -: CW];
          col_q <= stk_rdata[TW +: CW];
          if (stk_rdata[TW-1:0] != '0) begin
            choice_q <= 5'(stk_rdata[TW-1:0]) - 5'd1;
            state_q <= S_DONE;
          end else state_q <= S_POP;
        end
        S_DONE: begin
          result_o <= '{row: 6'(hr_q), column: 6'(hc_q), tried_tile: 4'(ch_q),
                        status: status_q};
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/emtp_checker.sv
// Port checker for the edge matching tile placer, bound to the top level.
// Depends on emtp_pkg.
module emtp_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input emtp_pkg::req_t req_i,
  input emtp_pkg::res_t result_o
);

  // A result only ever appears while the block is ready for the next request.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // Every result carries one of the defined status codes.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status <= emtp_pkg::StNoTiling)) else $error("bad status");

  // A load request answers with status loaded in the cycle after it is taken.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !req_i.kind) |=> (done_o && result_o.status == emtp_pkg::StLoaded))
    else $error("load result missing");

  // Outside a result, the block must be busy or idle consistently: a taken search
  // request keeps the block busy or gives its result.
  a_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.kind) |=> (busy || done_o)) else $error("search lost");

endmodule

bind edge_matching_tile_placer emtp_checker u_emtp_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .req_i, .result_o
);

FILE: test/testbench.sv
// Self-checking testbench for the edge matching tile placer.
// Depends on emtp_pkg and the RTL top level edge_matching_tile_placer.
// Tile sets are loaded and search ticks issued; each result is checked against an in-bench search.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RunLimit = 3_000_000;
  localparam int unsigned ReqW = $bits(emtp_pkg::req_t);

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  emtp_pkg::req_t req_i = '0;
  logic           done_o;
  emtp_pkg::res_t result_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [4:0]     cfg_data_i = 5'd16;

  edge_matching_tile_placer uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .result_o(result_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Mirror of the search state.
  logic [11:0] tile_edges[emtp_pkg::MaxTiles][4];
  logic [3:0]  placed_tile[emtp_pkg::Cells];
  bit          cell_used[emtp_pkg::Cells];
  logic [5:0]  trail_row[emtp_pkg::Cells];
  logic [5:0]  trail_col[emtp_pkg::Cells];
  logic [3:0]  trail_tile[emtp_pkg::Cells];
  int unsigned trail_depth = 0;
  int unsigned cur_row = 0, cur_col = 0, cur_choice = 0;
  bit          started = 0, halted = 0;
  logic [4:0]  tile_count = 5'd16;

  emtp_pkg::res_t pending_results[$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          idling_on = 1'b1;
  logic [11:0] palette[4];
  int unsigned palette_size = 1;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RunLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic int unsigned active_tiles();
    if (tile_count == 0) return 1;
    if (tile_count > emtp_pkg::MaxTiles) return emtp_pkg::MaxTiles;
    return 32'(tile_count);
  endfunction

  // An empty neighbour always matches; otherwise the facing edges must be equal.
  function automatic bit side_matches(int unsigned t, int side, int unsigned r,
                                      int unsigned c, int nside);
    int unsigned idx;
    idx = r * emtp_pkg::GridSide + c;
    if (!cell_used[idx]) return 1'b1;
    return tile_edges[t][side] == tile_edges[placed_tile[idx]][nside];
  endfunction

  function automatic bit tile_fits(int unsigned r, int unsigned c);
    int unsigned t;
    t = 32'(placed_tile[r * emtp_pkg::GridSide + c]);
    if (r + 1 < emtp_pkg::GridSide && !side_matches(t, 1, r + 1, c, 3)) return 1'b0;
    if (c + 1 < emtp_pkg::GridSide && !side_matches(t, 0, r, c + 1, 2)) return 1'b0;
    if (r > 0 && !side_matches(t, 3, r - 1, c, 1)) return 1'b0;
    if (c > 0 && !side_matches(t, 2, r, c - 1, 0)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit at_border();
    return cur_row >= emtp_pkg::GridSide - 1 || cur_col >= emtp_pkg::GridSide - 1;
  endfunction

  // Advances the mirrored search by one request and returns the result it should give.
  function automatic emtp_pkg::res_t search_tick(emtp_pkg::req_t rq);
    emtp_pkg::res_t res;
    int unsigned r, c, ch, idx;
    int          next_choice;
    res = '0;
    if (!rq.kind) begin
      tile_edges[rq.tile_slot][0] = rq.edge_top;
      tile_edges[rq.tile_slot][1] = rq.edge_right;
      tile_edges[rq.tile_slot][2] = rq.edge_bottom;
      tile_edges[rq.tile_slot][3] = rq.edge_left;
      res.tried_tile = rq.tile_slot;
      res.status = emtp_pkg::StLoaded;
      return res;
    end
    if (!started) begin
      started = 1'b1;
      cur_choice = active_tiles() - 1;
    end
    if (!halted && at_border()) halted = 1'b1;
    if (halted) begin
      res.row = cur_row[5:0];
      res.column = cur_col[5:0];
      res.status = at_border() ? emtp_pkg::StFull : emtp_pkg::StNoTiling;
      return res;
    end
    r = cur_row;
    c = cur_col;
    ch = cur_choice % emtp_pkg::MaxTiles;
    placed_tile[r * emtp_pkg::GridSide + c] = ch[3:0];
    cell_used[r * emtp_pkg::GridSide + c] = 1'b1;
    res.row = r[5:0];
    res.column = c[5:0];
    res.tried_tile = ch[3:0];
    if (tile_fits(r, c)) begin
      res.status = emtp_pkg::StPlaced;
      trail_row[trail_depth] = r[5:0];
      trail_col[trail_depth] = c[5:0];
      trail_tile[trail_depth] = ch[3:0];
      trail_depth++;
      cur_choice = active_tiles() - 1;
      // Diagonal shell order.
      if (c < r) cur_col = c + 1;
      else if (r == 0) begin
        cur_row = c + 1;
        cur_col = 0;
      end else cur_row = r - 1;
    end else begin
      next_choice = int'(ch) - 1;
      res.status = (next_choice < 0) ? emtp_pkg::StBacktrack : emtp_pkg::StRejected;
      while (next_choice < 0) begin
        idx = cur_row * emtp_pkg::GridSide + cur_col;
        cell_used[idx] = 1'b0;
        if (trail_depth == 0) begin
          halted = 1'b1;
          res.status = emtp_pkg::StNoTiling;
          next_choice = 0;
          break;
        end
        trail_depth--;
        cur_row = 32'(trail_row[trail_depth]);
        cur_col = 32'(trail_col[trail_depth]);
        next_choice = int'(trail_tile[trail_depth]) - 1;
      end
      cur_choice = next_choice;
    end
    return res;
  endfunction

  // Results are compared with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    emtp_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.row !== want.row)
          $display("%0t: row expected %0d actual %0d", $time, want.row, result_o.row);
        if (result_o.column !== want.column)
          $display("%0t: column expected %0d actual %0d", $time, want.column,
                   result_o.column);
        if (result_o.tried_tile !== want.tried_tile)
          $display("%0t: tried_tile expected %0d actual %0d", $time, want.tried_tile,
                   result_o.tried_tile);
        if (result_o.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result_o.status);
        if (result_o !== want) failures++;
      end
    end
  end

  // Random pause before a request, now and then.
  task automatic maybe_pause();
    if (idling_on && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 19)) @(negedge clk_i);
  endtask

  task automatic send_request(emtp_pkg::req_t rq);
    emtp_pkg::res_t expected;
    maybe_pause();
    @(negedge clk_i);
    start = 1'b1;
    req_i = rq;
    do @(posedge clk_i); while (busy);
    expected = search_tick(rq);
    pending_results = {pending_results, expected};
    items_sent++;
    @(negedge clk_i);
    start = 1'b0;
    req_i = '0;
  endtask

  task automatic load_tile(logic [3:0] slot, logic [11:0] t, logic [11:0] rt,
                           logic [11:0] b, logic [11:0] l);
    emtp_pkg::req_t rq;
    rq = '0;
    rq.kind = 1'b0;
    rq.tile_slot = slot;
    rq.edge_top = t;
    rq.edge_right = rt;
    rq.edge_bottom = b;
    rq.edge_left = l;
    send_request(rq);
  endtask

  // A search tick carries random, ignored edge fields.
  task automatic search_step();
    emtp_pkg::req_t rq;
    rq = ReqW'({$urandom, $urandom});
    rq.kind = 1'b1;
    send_request(rq);
  endtask

  // The register is written only with nothing outstanding.
  task automatic write_tile_count(logic [4:0] value);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tile_count = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [11:0] pick_colour();
    return palette[$urandom_range(0, palette_size - 1)];
  endfunction

  task automatic load_random_set(int unsigned colours);
    palette_size = colours;
    foreach (palette[i]) palette[i] = 12'($urandom_range(0, 4095));
    for (int s = 0; s < emtp_pkg::MaxTiles; s++)
      load_tile(s[3:0], pick_colour(), pick_colour(), pick_colour(), pick_colour());
  endtask

  // Field extremes on loads, count extremes, then the first search ticks.
  task automatic test_directed();
    write_tile_count(5'd31);
    load_tile(4'd0, 12'h000, 12'h000, 12'h000, 12'h000);
    load_tile(4'd15, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    for (int s = 1; s < emtp_pkg::MaxTiles - 1; s++)
      load_tile(s[3:0], 12'h5a5, 12'h5a5, 12'h5a5, 12'ha5a);
    write_tile_count(5'd0);
    write_tile_count(5'd16);
    // Tile 15 fits first and then fits again at each following cell, beside copies of itself.
    repeat (6) search_step();
  endtask

  // Phases of ticks over random sets and counts, with loads during the search.
  task automatic test_random_search();
    int unsigned phase_len;
    while (items_sent < 1500) begin
      write_tile_count(5'($urandom_range(0, 31)));
      load_random_set($urandom_range(1, 3));
      phase_len = $urandom_range(20, 150);
      repeat (phase_len) begin
        if ($urandom_range(0, 15) == 0)
          load_tile(4'($urandom_range(0, 15)), pick_colour(), pick_colour(), pick_colour(),
                    pick_colour());
        else search_step();
      end
    end
  endtask

  // A set whose right and left edges never meet exhausts the search, which then halts.
  task automatic test_exhaust_search();
    write_tile_count(5'($urandom_range(0, 5)));
    idling_on = 1'b0;
    for (int s = 0; s < emtp_pkg::MaxTiles; s++)
      load_tile(s[3:0], 12'h111, 12'h222, 12'h111, 12'h333);
    while (!halted) search_step();
    repeat (5) search_step();
  endtask

  initial begin
    foreach (cell_used[i]) cell_used[i] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_search();
    test_exhaust_search();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (failures == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
